### src/asht_pkg.sv
// Package for the address/size hash table: constants, status codes, hash constants.
// No dependencies.
package asht_pkg;

    localparam int unsigned TableEntriesDefault = 4096;
    localparam int unsigned ProbeLimitDefault   = 32;

    localparam logic [63:0] HashMul1 = 64'h0000_0000_85eb_ca6b;
    localparam logic [63:0] HashMul2 = 64'h0000_0000_c2b2_ae35;

    localparam int unsigned FifoDepth = 2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_TAKE  = 1'b1;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic        req_type;
        logic        table_sel;
        logic        is_zero;
        logic [63:0] address;
        logic [63:0] store_size;
        logic [63:0] hash;
    } t_job;

endpackage

### src/address_size_hash_table_unit.sv
// Address/size hash table: two open-addressing tables with linear probing.
// Push a request (store or take); pop one result per request, in order.
// A three-stage hash pipeline feeds a two-entry queue; the back end probes
// one slot at a time (registered memory read, then compare).
// The back end finishes one request, probe loop included, before it takes
// the next; a take hit adds a size-read step, a zero address skips probing.
// Reset (i_rst_n low, synchronous): control clears, then the back end runs a
// clearing pass over all TABLE_ENTRIES slots of both key tables; requests are
// accepted into the front and wait until it ends.
// When the receiver does not pop, the one-entry result register holds and
// the back end stalls; the queue and hash pipeline keep accepting until full.
module address_size_hash_table_unit #(
    parameter int unsigned TABLE_ENTRIES = asht_pkg::TableEntriesDefault,
    parameter int unsigned PROBE_LIMIT   = asht_pkg::ProbeLimitDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic        i_table_sel,
    input  logic [63:0] i_address,
    input  logic [63:0] i_store_size,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [63:0] o_found_size
);
    import asht_pkg::*;

    logic f_valid, f_ready, q_valid, q_ready, clearing;
    t_job f_job, q_job;

    asht_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_req_type, .i_table_sel, .i_address, .i_store_size,
        .o_job_valid(f_valid), .o_job(f_job), .i_job_ready(f_ready)
    );

    asht_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_job(f_job),
        .o_rd_valid(q_valid), .i_rd_ready(q_ready), .o_rd_job(q_job)
    );

    asht_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .o_busy_clear(clearing),
        .o_empty(empty), .i_pop(pop), .o_status, .o_found_size
    );

`ifndef SYNTH
    // no job leaves the queue during the clearing pass
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !q_ready) else $error("job taken while clearing");
    // a result that is not a hit (miss or zero address) never carries a size
    a_zero_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (o_found_size == 64'd0))
        else $error("size on non-hit");
    // a result that is not popped holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_found_size)))
        else $error("result changed while stalled");
`endif
endmodule

### src/asht_front.sv
// Front end: accepts requests and runs the two-multiply hash pipeline.
// Depends on asht_pkg.
module asht_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_req_type,
    input  logic              i_table_sel,
    input  logic [63:0]       i_address,
    input  logic [63:0]       i_store_size,
    output logic              o_job_valid,
    output asht_pkg::t_job    o_job,
    input  logic              i_job_ready
);
    import asht_pkg::*;

    // three stages: xor/mul1, xor/mul2, final xor
    logic [2:0]  r_vld;
    t_job        r_s0, r_s1, r_s2;
    logic        adv2, adv1, adv0;
    logic [63:0] k0, k1, k2;

    // 64x32 product mod 2^64 from two 32x32 partial products
    function automatic logic [63:0] mul_c(input logic [63:0] a, input logic [31:0] c);
        logic [63:0] lo;
        logic [31:0] hi;
        lo = {32'd0, a[31:0]} * {32'd0, c};
        hi = a[63:32] * c;
        return {lo[63:32] + hi, lo[31:0]};
    endfunction

    assign adv2 = !r_vld[2] || i_job_ready;
    assign adv1 = !r_vld[1] || adv2;
    assign adv0 = !r_vld[0] || adv1;
    assign o_full = !adv0;

    assign k0 = {12'd0, i_address[63:12]};
    assign k1 = r_s0.hash ^ (r_s0.hash >> 13);
    assign k2 = r_s1.hash ^ (r_s1.hash >> 16);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv2) r_vld[2] <= r_vld[1];
            if (adv1) r_vld[1] <= r_vld[0];
            if (adv0) r_vld[0] <= i_push;
        end
    end

    // payload and hash stages
    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_s0.req_type   <= i_req_type;
            r_s0.table_sel  <= i_table_sel;
            r_s0.is_zero    <= (i_address == 64'd0);
            r_s0.address    <= i_address;
            r_s0.store_size <= i_store_size;
            r_s0.hash       <= mul_c(k0 ^ (k0 >> 16), HashMul1[31:0]);
        end
        if (adv1) begin
            r_s1.req_type   <= r_s0.req_type;
            r_s1.table_sel  <= r_s0.table_sel;
            r_s1.is_zero    <= r_s0.is_zero;
            r_s1.address    <= r_s0.address;
            r_s1.store_size <= r_s0.store_size;
            r_s1.hash       <= mul_c(k1, HashMul2[31:0]);
        end
        if (adv2) begin
            r_s2.req_type   <= r_s1.req_type;
            r_s2.table_sel  <= r_s1.table_sel;
            r_s2.is_zero    <= r_s1.is_zero;
            r_s2.address    <= r_s1.address;
            r_s2.store_size <= r_s1.store_size;
            r_s2.hash       <= k2;
        end
    end

    assign o_job_valid = r_vld[2];
    assign o_job       = r_s2;
endmodule

### src/asht_queue.sv
// Short job queue between the front and the back.
// Depends on asht_pkg.
module asht_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  asht_pkg::t_job i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output asht_pkg::t_job o_rd_job
);
    import asht_pkg::*;

    t_job r_mem [FifoDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_wr_ready = (r_cnt != 2'(FifoDepth));
    assign o_rd_valid = (r_cnt != 2'd0);
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;
    assign o_rd_job = r_mem[r_rp];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_job;
    end
endmodule

### src/asht_back.sv
// Back end: probes the selected table linearly, updates it, holds results in a one-entry output register.
// Depends on asht_pkg.
module asht_back #(
    parameter int unsigned TABLE_ENTRIES = asht_pkg::TableEntriesDefault,
    parameter int unsigned PROBE_LIMIT   = asht_pkg::ProbeLimitDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  asht_pkg::t_job i_job,
    output logic           o_busy_clear,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [1:0]     o_status,
    output logic [63:0]    o_found_size
);
    import asht_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_CHECK, S_SIZE, S_OUT
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [AW-1:0] r_idx;
    logic [PW-1:0] r_probe;
    logic [1:0]  r_status;
    logic [63:0] r_size;
    logic        r_ovld;
    logic [1:0]  r_ost;
    logic [63:0] r_osz;

    logic [63:0] r_keys0 [TABLE_ENTRIES];
    logic [63:0] r_keys1 [TABLE_ENTRIES];
    logic [63:0] r_sizes0 [TABLE_ENTRIES];
    logic [63:0] r_sizes1 [TABLE_ENTRIES];
    logic [63:0] r_kq0, r_kq1, r_sq0, r_sq1;
    logic [63:0] cur_key, cur_size;

    logic        kwe, swe;
    logic [63:0] kwd;
    logic        tsel;

    assign cur_key  = r_job.table_sel ? r_kq1 : r_kq0;
    assign cur_size = r_job.table_sel ? r_sq1 : r_sq0;
    assign o_job_ready = (r_state == S_IDLE) && !r_ovld;
    assign o_busy_clear = (r_state == S_CLEAR);
    assign o_empty = !r_ovld;
    assign o_status = r_ost;
    assign o_found_size = r_osz;

    // memory write controls
    always_comb begin
        kwe  = 1'b0;
        swe  = 1'b0;
        kwd  = 64'd0;
        tsel = r_job.table_sel;
        if (r_state == S_CLEAR) begin
            kwe = 1'b1;
        end else if (r_state == S_CHECK) begin
            if (r_job.req_type == REQ_STORE &&
                (cur_key == r_job.address || cur_key == 64'd0)) begin
                kwe = 1'b1;
                swe = 1'b1;
                kwd = r_job.address;
            end else if (r_job.req_type == REQ_TAKE && cur_key == r_job.address) begin
                kwe = 1'b1;
            end
        end
    end

    // table memories, registered reads
    always_ff @(posedge i_clk) begin
        if (kwe && (r_state == S_CLEAR || !tsel)) r_keys0[r_idx] <= kwd;
        if (kwe && (r_state == S_CLEAR || tsel))  r_keys1[r_idx] <= kwd;
        if (swe && !tsel) r_sizes0[r_idx] <= r_job.store_size;
        if (swe && tsel)  r_sizes1[r_idx] <= r_job.store_size;
        r_kq0 <= r_keys0[r_idx];
        r_kq1 <= r_keys1[r_idx];
        r_sq0 <= r_sizes0[r_idx];
        r_sq1 <= r_sizes1[r_idx];
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_pop && r_ovld) r_ovld <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == AW'(TABLE_ENTRIES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_job_valid && !r_ovld) begin
                        r_job    <= i_job;
                        r_idx    <= i_job.hash[AW-1:0];
                        r_probe  <= '0;
                        r_status <= ST_MISS;
                        r_size   <= 64'd0;
                        if (i_job.is_zero) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (cur_key == r_job.address ||
                        (cur_key == 64'd0 && r_job.req_type == REQ_STORE)) begin
                        r_status <= ST_OK;
                        r_state  <= (r_job.req_type == REQ_TAKE) ? S_SIZE : S_OUT;
                    end else if (cur_key == 64'd0 ||
                                 r_probe == PW'(PROBE_LIMIT - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_probe <= r_probe + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_SIZE: begin
                    r_size  <= cur_size;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovld  <= 1'b1;
                    r_ost   <= r_status;
                    r_osz   <= r_size;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
